FILE: hw/rtl/cip_pkg.sv
// Shared types, constants and CRC helper for the container index parser.
// No dependencies.
package cip_pkg;

    localparam int HEADER_BYTES = 12;
    localparam int INDEX_BYTES = 12;
    localparam int CRC_FROM_DEF = 12;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam logic [31:0] MAGIC_RESET = 32'h534E_4942;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_SHORT_HDR = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
    localparam logic [2:0] ST_INDEX_LONG = 3'd3;
    localparam logic [2:0] ST_ENTRY_RANGE = 3'd4;

    localparam logic CFG_LENGTH = 1'b0;
    localparam logic CFG_MAGIC = 1'b1;

    localparam logic KIND_ENTRY = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Per-byte result record handed from front to back
    typedef struct packed {
        logic        has_entry;
        logic        has_sum;
        logic [31:0] e_num;
        logic [31:0] e_key;
        logic [31:0] e_off;
        logic [31:0] e_size;
        logic [31:0] s_done;
        logic [31:0] s_total;
        logic [31:0] s_stored;
        logic [31:0] s_crc;
        logic [2:0]  s_status;
    } t_rec;

    function automatic logic [31:0] crc_nib(input logic [3:0] idx);
        logic [31:0] v;
        case (idx)
            4'h0: v = 32'h00000000;
            4'h1: v = 32'h1db71064;
            4'h2: v = 32'h3b6e20c8;
            4'h3: v = 32'h26d930ac;
            4'h4: v = 32'h76dc4190;
            4'h5: v = 32'h6b6b51f4;
            4'h6: v = 32'h4db26158;
            4'h7: v = 32'h5005713c;
            4'h8: v = 32'hedb88320;
            4'h9: v = 32'hf00f9344;
            4'ha: v = 32'hd6d6a3e8;
            4'hb: v = 32'hcb61b38c;
            4'hc: v = 32'h9b64c2b0;
            4'hd: v = 32'h86d3d2d4;
            4'he: v = 32'ha00ae278;
            default: v = 32'hbdbdf21c;
        endcase
        return v;
    endfunction

    // reflected CRC-32, two nibbles per byte
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] t;
        t = (c >> 4) ^ crc_nib(c[3:0] ^ b[3:0]);
        t = (t >> 4) ^ crc_nib(t[3:0] ^ b[7:4]);
        return t;
    endfunction

endpackage

FILE: hw/rtl/cip_front.sv
// Front end: accepts image bytes, tracks header/index parse state and CRC,
// builds one result record per byte that causes results. Uses cip_pkg.
module cip_front #(
    parameter int CRC_FROM = cip_pkg::CRC_FROM_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_image,
    input  logic        i_q_full,
    output logic        o_push,
    output cip_pkg::t_rec o_rec
);
    import cip_pkg::*;

    localparam logic [32:0] POS_MAX = '1;

    logic [31:0] r_len, r_magic;
    logic [32:0] r_pos, n_pos;
    logic [31:0] r_word, n_word;
    logic [31:0] r_count, n_count;
    logic [31:0] r_stored, n_stored;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_key, n_key;
    logic [31:0] r_off, n_off;
    logic [31:0] r_done, n_done;
    logic [36:0] r_iend, n_iend;
    logic [2:0]  r_err, n_err;
    logic [3:0]  r_phase, n_phase;
    logic        accept, have, in_idx, past_hdr, not_max;
    logic [32:0] endp;

    assign o_stall = i_q_full;
    assign accept = i_valid && !i_q_full;

    always_comb begin
        n_word = {i_data_byte, r_word[31:8]};
        not_max = (r_pos != POS_MAX);
        past_hdr = (r_pos >= 33'(HEADER_BYTES));
        n_crc = (r_pos >= 33'(CRC_FROM)) ? crc_byte(r_crc, i_data_byte) : r_crc;
        n_err = r_err;
        n_count = r_count;
        n_iend = r_iend;
        n_stored = r_stored;
        n_key = r_key;
        n_off = r_off;
        n_done = r_done;
        have = 1'b0;
        endp = 33'(r_off) + 33'(n_word);
        if (r_pos == 33'd0 && r_len < 32'(HEADER_BYTES) && n_err == ST_OK)
            n_err = ST_SHORT_HDR;
        if (r_pos == 33'd3) begin
            if (n_word != r_magic && n_err == ST_OK)
                n_err = ST_BAD_MAGIC;
        end else if (r_pos == 33'd7) begin
            n_count = n_word;
            n_iend = (37'(n_word) << 3) + (37'(n_word) << 2) + 37'(HEADER_BYTES);
            if (n_iend > 37'(r_len) && n_err == ST_OK)
                n_err = ST_INDEX_LONG;
        end else if (r_pos == 33'd11) begin
            n_stored = n_word;
        end
        in_idx = (r_err == ST_OK) && past_hdr && (37'(r_pos) < r_iend);
        if (in_idx && r_phase[1:0] == 2'd3) begin
            case (r_phase[3:2])
                2'd0: n_key = n_word;
                2'd1: n_off = n_word;
                default: begin
                    if (37'(r_off) < r_iend || endp > 33'(r_len)) begin
                        n_err = ST_ENTRY_RANGE;
                    end else begin
                        have = 1'b1;
                        n_done = r_done + 32'd1;
                    end
                end
            endcase
        end
        n_pos = not_max ? r_pos + 33'd1 : r_pos;
        n_phase = r_phase;
        if (past_hdr && not_max)
            n_phase = (r_phase == 4'(INDEX_BYTES - 1)) ? 4'd0 : r_phase + 4'd1;
        // early end of image
        if (i_end_of_image && n_err == ST_OK) begin
            if (n_pos < 33'(HEADER_BYTES))
                n_err = ST_SHORT_HDR;
            else if (37'(n_pos) < n_iend)
                n_err = ST_INDEX_LONG;
        end
    end

    always_comb begin
        o_rec.has_entry = have;
        o_rec.has_sum = i_end_of_image;
        o_rec.e_num = r_done;
        o_rec.e_key = r_key;
        o_rec.e_off = r_off;
        o_rec.e_size = n_word;
        o_rec.s_done = n_done;
        o_rec.s_total = n_count;
        o_rec.s_stored = n_stored;
        o_rec.s_crc = ~n_crc;
        o_rec.s_status = n_err;
    end
    assign o_push = accept && (have || i_end_of_image);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_magic <= MAGIC_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_LENGTH) r_len <= i_cfg_data;
            else r_magic <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_end_of_image)) begin
            r_pos <= '0;
            r_word <= '0;
            r_count <= '0;
            r_stored <= '0;
            r_crc <= '1;
            r_key <= '0;
            r_off <= '0;
            r_done <= '0;
            r_iend <= 37'(HEADER_BYTES);
            r_err <= ST_OK;
            r_phase <= '0;
        end else if (accept) begin
            r_pos <= n_pos;
            r_word <= n_word;
            r_count <= n_count;
            r_stored <= n_stored;
            r_crc <= n_crc;
            r_key <= n_key;
            r_off <= n_off;
            r_done <= n_done;
            r_iend <= n_iend;
            r_err <= n_err;
            r_phase <= n_phase;
        end
    end

endmodule

FILE: hw/rtl/cip_queue.sv
// Small record queue between front and back ends. Uses cip_pkg.
module cip_queue #(
    parameter int DEPTH = cip_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cip_pkg::t_rec i_rec,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output cip_pkg::t_rec o_head
);
    import cip_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_rec            r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;

    assign o_full = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head = r_mem[r_rp];

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] a);
        return (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= inc(r_wp);
            if (i_pop) r_rp <= inc(r_rp);
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue count over depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("pop from empty queue");

endmodule

FILE: hw/rtl/cip_back.sv
// Back end: expands queued records into entry and summary items and holds
// them in the output register. Uses cip_pkg.
module cip_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  cip_pkg::t_rec i_head,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic          o_item_kind,
    output logic [31:0]   o_entry_number,
    output logic [31:0]   o_name_key,
    output logic [31:0]   o_data_offset,
    output logic [31:0]   o_data_size,
    output logic [31:0]   o_entry_total,
    output logic [31:0]   o_crc_stored,
    output logic [31:0]   o_crc_computed,
    output logic [2:0]    o_status,
    output logic          o_final_result
);
    import cip_pkg::*;

    logic r_valid, r_sent, load, take_entry;

    assign load = !r_valid || !i_stall;
    assign take_entry = i_head.has_entry && !r_sent;
    assign o_pop = load && !i_empty && !(take_entry && i_head.has_sum);
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sent <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty)
                r_sent <= take_entry && i_head.has_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            if (take_entry) begin
                o_item_kind <= KIND_ENTRY;
                o_entry_number <= i_head.e_num;
                o_name_key <= i_head.e_key;
                o_data_offset <= i_head.e_off;
                o_data_size <= i_head.e_size;
                o_entry_total <= '0;
                o_crc_stored <= '0;
                o_crc_computed <= '0;
                o_status <= ST_OK;
                o_final_result <= !i_head.has_sum;
            end else begin
                o_item_kind <= KIND_SUMMARY;
                o_entry_number <= i_head.s_done;
                o_name_key <= '0;
                o_data_offset <= '0;
                o_data_size <= '0;
                o_entry_total <= i_head.s_total;
                o_crc_stored <= i_head.s_stored;
                o_crc_computed <= i_head.s_crc;
                o_status <= i_head.s_status;
                o_final_result <= 1'b1;
            end
        end
    end

    a_entry_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && o_item_kind == KIND_ENTRY) |-> (o_status == ST_OK && o_crc_computed == '0))
        else $error("entry item carries summary data");
    a_split_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sent |-> (r_valid && o_item_kind == KIND_ENTRY && !o_final_result))
        else $error("split record without pending entry");
    a_summary_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && o_item_kind == KIND_SUMMARY) |-> o_final_result)
        else $error("summary not marked final");

endmodule

FILE: hw/rtl/container_index_parser.sv
// Container index parser top level: front parser, record queue, back end.
// Depends on cip_pkg, cip_front, cip_queue, cip_back.
//
// Input channel: one image byte per item (i_data_byte, i_end_of_image),
// accepted when i_valid is high and o_stall is low. Output channel: index
// entries and the end-of-image summary, taken when o_valid is high and
// i_stall is low. Registers (length, magic) are written through i_cfg_we,
// i_cfg_index and i_cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce. Throughput: one
// byte per cycle while o_stall is low. A byte that completes an index
// entry and also ends the image makes two items, which the back end sends
// one after the other; the queue absorbs the extra item. A result's record
// is written into the queue when its byte is accepted, and the output
// register is loaded from the queue after that unless i_stall holds it.
// When the receiver stalls, the output item holds, the queue fills, and
// o_stall rises once the queue is full.
// Reset (synchronous, active low) empties the queue, clears parse state and
// loads the default length (0) and magic word; no clearing pass is needed.
module container_index_parser #(
    parameter int CRC_FROM = cip_pkg::CRC_FROM_DEF,
    parameter int QUEUE_DEPTH = cip_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_image,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_item_kind,
    output logic [31:0] o_entry_number,
    output logic [31:0] o_name_key,
    output logic [31:0] o_data_offset,
    output logic [31:0] o_data_size,
    output logic [31:0] o_entry_total,
    output logic [31:0] o_crc_stored,
    output logic [31:0] o_crc_computed,
    output logic [2:0]  o_status,
    output logic        o_final_result
);
    import cip_pkg::*;

    t_rec push_rec, head_rec;
    logic push, pop, q_full, q_empty;

    cip_front #(.CRC_FROM(CRC_FROM)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_data_byte(i_data_byte), .i_end_of_image(i_end_of_image),
        .i_q_full(q_full), .o_push(push), .o_rec(push_rec)
    );

    cip_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_rec(push_rec), .i_pop(pop),
        .o_full(q_full), .o_empty(q_empty), .o_head(head_rec)
    );

    cip_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(q_empty), .i_head(head_rec), .o_pop(pop),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_item_kind(o_item_kind), .o_entry_number(o_entry_number),
        .o_name_key(o_name_key), .o_data_offset(o_data_offset),
        .o_data_size(o_data_size), .o_entry_total(o_entry_total),
        .o_crc_stored(o_crc_stored), .o_crc_computed(o_crc_computed),
        .o_status(o_status), .o_final_result(o_final_result)
    );

endmodule

FILE: tb/cip_checker.sv
// Watches both channels and the register port of container_index_parser,
// predicts the entries and summaries it must emit, and compares them.
// Depends on cip_pkg.
module cip_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_image,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic        o_item_kind,
    input  logic [31:0] o_entry_number,
    input  logic [31:0] o_name_key,
    input  logic [31:0] o_data_offset,
    input  logic [31:0] o_data_size,
    input  logic [31:0] o_entry_total,
    input  logic [31:0] o_crc_stored,
    input  logic [31:0] o_crc_computed,
    input  logic [2:0]  o_status,
    input  logic        o_final_result,
    output int          o_fail_count,
    output int          o_pending
);
    import cip_pkg::*;

    localparam logic [32:0] POS_LIMIT = '1;

    typedef struct {
        logic        kind;
        logic [31:0] num;
        logic [31:0] key;
        logic [31:0] off;
        logic [31:0] size;
        logic [31:0] total;
        logic [31:0] crc_st;
        logic [31:0] crc_calc;
        logic [2:0]  status;
        logic        fin;
    } t_parse_result;

    t_parse_result awaited_results[$];

    logic [31:0] len_reg, magic_reg;
    logic [32:0] pos;
    logic [31:0] shift_word, count_hdr, crc_hdr, crc_run, key_hold, off_hold, emitted;
    logic [63:0] table_end;
    logic [2:0]  err;

    int fails = 0;
    assign o_fail_count = fails;
    assign o_pending = awaited_results.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fails++;
    endtask

    task automatic expect_item(input t_parse_result r);
        awaited_results.insert(awaited_results.size(), r);
    endtask

    task automatic clear_parse();
        pos = '0;
        shift_word = '0;
        count_hdr = '0;
        crc_hdr = '0;
        crc_run = '1;
        key_hold = '0;
        off_hold = '0;
        emitted = '0;
        table_end = HEADER_BYTES;
        err = ST_OK;
    endtask

    function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            v = v[0] ? ((v >> 1) ^ 32'hEDB88320) : (v >> 1);
        return v;
    endfunction

    task automatic flag(input logic [2:0] code);
        if (err == ST_OK)
            err = code;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last);
        t_parse_result r;
        logic [63:0] rel, slot, stop;
        logic got_entry;
        got_entry = 1'b0;
        r = '{default: '0};
        shift_word = {b, shift_word[31:8]};
        if (pos >= CRC_FROM_DEF)
            crc_run = crc32_step(crc_run, b);
        if (pos == 0 && len_reg < HEADER_BYTES)
            flag(ST_SHORT_HDR);
        if (pos == 3) begin
            if (shift_word != magic_reg)
                flag(ST_BAD_MAGIC);
        end else if (pos == 7) begin
            count_hdr = shift_word;
            table_end = 64'(HEADER_BYTES) + 64'(count_hdr) * INDEX_BYTES;
            if (table_end > 64'(len_reg))
                flag(ST_INDEX_LONG);
        end else if (pos == 11) begin
            crc_hdr = shift_word;
        end
        if (err == ST_OK && pos >= HEADER_BYTES && 64'(pos) < table_end) begin
            rel = 64'(pos) - HEADER_BYTES;
            slot = rel % INDEX_BYTES;
            if (slot[1:0] == 2'd3) begin
                case (slot >> 2)
                    0: key_hold = shift_word;
                    1: off_hold = shift_word;
                    default: begin
                        stop = 64'(off_hold) + 64'(shift_word);
                        if (64'(off_hold) < table_end || stop > 64'(len_reg)) begin
                            flag(ST_ENTRY_RANGE);
                        end else begin
                            got_entry = 1'b1;
                            r.kind = KIND_ENTRY;
                            r.num = emitted;
                            r.key = key_hold;
                            r.off = off_hold;
                            r.size = shift_word;
                            r.fin = !last;
                            emitted = emitted + 32'd1;
                        end
                    end
                endcase
            end
        end
        if (pos != POS_LIMIT)
            pos = pos + 1;
        if (got_entry)
            expect_item(r);
        if (last) begin
            if (err == ST_OK) begin
                if (pos < HEADER_BYTES)
                    err = ST_SHORT_HDR;
                else if (64'(pos) < table_end)
                    err = ST_INDEX_LONG;
            end
            r = '{default: '0};
            r.kind = KIND_SUMMARY;
            r.num = emitted;
            r.total = count_hdr;
            r.crc_st = crc_hdr;
            r.crc_calc = ~crc_run;
            r.status = err;
            r.fin = 1'b1;
            expect_item(r);
            clear_parse();
        end
    endtask

    task automatic compare_output();
        t_parse_result e;
        if (awaited_results.size() == 0) begin
            report("unexpected item", 32'(o_item_kind), 32'd0);
            return;
        end
        e = awaited_results.pop_front();
        if (o_item_kind !== e.kind) report("item_kind", o_item_kind, e.kind);
        if (o_entry_number !== e.num) report("entry_number", o_entry_number, e.num);
        if (o_name_key !== e.key) report("name_key", o_name_key, e.key);
        if (o_data_offset !== e.off) report("data_offset", o_data_offset, e.off);
        if (o_data_size !== e.size) report("data_size", o_data_size, e.size);
        if (o_entry_total !== e.total) report("entry_total", o_entry_total, e.total);
        if (o_crc_stored !== e.crc_st) report("crc_stored", o_crc_stored, e.crc_st);
        if (o_crc_computed !== e.crc_calc) report("crc_computed", o_crc_computed, e.crc_calc);
        if (o_status !== e.status) report("status", o_status, e.status);
        if (o_final_result !== e.fin) report("final_result", o_final_result, e.fin);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            len_reg = '0;
            magic_reg = MAGIC_RESET;
            clear_parse();
            awaited_results.delete();
        end else begin
            if (o_valid && !i_stall)
                compare_output();
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_LENGTH)
                    len_reg = i_cfg_data;
                else
                    magic_reg = i_cfg_data;
            end
            if (i_valid && !o_stall)
                parse_byte(i_data_byte, i_end_of_image);
        end
    end

endmodule

FILE: tb/tb.sv
// Top-level bench for container_index_parser: clock, reset, register writes,
// image stimulus and receiver stalls; checking lives in cip_checker.
// Depends on cip_pkg, container_index_parser, cip_checker.
module tb;
    import cip_pkg::*;

    typedef enum int {
        FLAW_NONE, FLAW_MAGIC, FLAW_COUNT, FLAW_LOW_OFF, FLAW_PAST_END,
        FLAW_WRAP, FLAW_TRUNC, FLAW_NOISE
    } t_flaw;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = CFG_LENGTH;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_end_of_image = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall, o_valid, o_item_kind, o_final_result;
    logic [31:0] o_entry_number, o_name_key, o_data_offset, o_data_size;
    logic [31:0] o_entry_total, o_crc_stored, o_crc_computed;
    logic [2:0]  o_status;
    int          fail_count, pending;

    container_index_parser uut (.*);
    cip_checker chk (.*, .o_fail_count(fail_count), .o_pending(pending));

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("FAIL container_index_parser");
        $finish;
    end

    // receiver: shifting stall pattern, plus one long hold on request
    logic hold_go = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;
    logic [8:0] pat_cnt = '0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_go && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_left <= 300;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            pat_cnt <= pat_cnt + 1;
            case (pat_cnt[8:7])
                2'd0: i_stall <= 1'b0;
                2'd1: i_stall <= ($urandom % 4) == 0;
                2'd2: i_stall <= ($urandom % 4) != 0;
                default: i_stall <= pat_cnt[2];
            endcase
        end
    end

    logic [7:0]  image_bytes[$];
    logic [31:0] len_now = '0;
    logic [31:0] magic_now = MAGIC_RESET;
    int          burst_left = 0;
    int          bytes_sent = 0;

    task automatic write_reg(input logic idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_LENGTH) len_now = val;
        else magic_now = val;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom % 4 == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_end_of_image <= last;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
    endtask

    task automatic add_byte(input logic [7:0] b);
        image_bytes.insert(image_bytes.size(), b);
    endtask

    task automatic put_word(input logic [31:0] w);
        for (int k = 0; k < 4; k++) add_byte(w[8*k +: 8]);
    endtask

    function automatic logic [63:0] rand64(input logic [63:0] lim);
        // uniform-ish in 0..lim
        logic [63:0] v;
        v = {$urandom, $urandom};
        return (lim == '1) ? v : v % (lim + 1);
    endfunction

    // builds an image of n entries plus trailing data; fl breaks one part
    task automatic build_image(input int n, input int extra, input t_flaw fl);
        logic [63:0] tbl_end, off, size, len64;
        logic [31:0] cnt;
        int bad;
        image_bytes.delete();
        len64 = 64'(len_now);
        if (fl == FLAW_NOISE) begin
            repeat ($urandom_range(1, 40)) add_byte(8'($urandom));
            return;
        end
        tbl_end = 12 + 12 * n;
        cnt = n;
        if (fl == FLAW_COUNT)
            cnt = ($urandom % 2) ? 32'hFFFF_FFFF : 32'((len64 / 12) + $urandom_range(1, 3));
        put_word(magic_now);
        if (fl == FLAW_MAGIC)
            image_bytes[$urandom % 4] ^= 8'(1 << ($urandom % 8));
        put_word(cnt);
        put_word($urandom);
        bad = (n > 0) ? $urandom % n : 0;
        for (int k = 0; k < n; k++) begin
            if (len64 >= tbl_end) begin
                off = tbl_end + rand64(len64 - tbl_end);
                size = rand64(len64 - off);
            end else begin
                off = tbl_end;
                size = 0;
            end
            if (k == bad) begin
                case (fl)
                    FLAW_LOW_OFF: off = rand64(tbl_end - 1);
                    FLAW_PAST_END: begin
                        off = tbl_end;
                        size = (len64 >= off) ? len64 - off + 1 : 1;
                    end
                    FLAW_WRAP: begin
                        off = 64'hFFFF_FFF0;
                        size = 64'h100;
                    end
                    default: ;
                endcase
            end
            put_word($urandom);
            put_word(off[31:0]);
            put_word(size[31:0]);
        end
        repeat (extra) add_byte(8'($urandom));
        if (fl == FLAW_TRUNC)
            image_bytes = image_bytes[0:$urandom_range(0, image_bytes.size() - 2)];
    endtask

    task automatic send_image(input int n, input int extra, input t_flaw fl);
        build_image(n, extra, fl);
        foreach (image_bytes[k])
            send_byte(image_bytes[k], k == image_bytes.size() - 1);
    endtask

    function automatic t_flaw pick_flaw();
        int r;
        r = $urandom % 100;
        if (r < 65) return FLAW_NONE;
        return t_flaw'($urandom_range(FLAW_MAGIC, FLAW_NOISE));
    endfunction

    initial begin
        int n_max, n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: length register left at reset value, so short header
        send_image(1, 0, FLAW_NONE);
        wait_drained();
        // last entry completes on the end byte: entry then summary together
        write_reg(CFG_LENGTH, 36);
        write_reg(CFG_MAGIC, 32'hFFFF_FFFF);
        send_image(2, 0, FLAW_NONE);
        send_image(0, 0, FLAW_NONE);
        wait_drained();
        write_reg(CFG_LENGTH, 32'hFFFF_FFFF);
        write_reg(CFG_MAGIC, 32'h0);
        send_image(1, 2, FLAW_WRAP);
        send_image(1, 0, FLAW_LOW_OFF);
        send_image(1, 0, FLAW_COUNT);
        send_image(1, 0, FLAW_MAGIC);
        wait_drained();
        write_reg(CFG_LENGTH, 11);
        send_image(0, 3, FLAW_NONE);
        send_byte(8'hFF, 1'b1);
        wait_drained();

        // long receiver hold while a big image streams in
        write_reg(CFG_MAGIC, MAGIC_RESET);
        write_reg(CFG_LENGTH, 12 + 12 * 12 + 40);
        hold_go <= 1'b1;
        send_image(12, 10, FLAW_NONE);
        wait_drained();

        while (bytes_sent < 1800) begin
            n_max = $urandom_range(0, 6);
            case ($urandom % 8)
                0: write_reg(CFG_LENGTH, 32'hFFFF_FFFF);
                1: write_reg(CFG_LENGTH, $urandom % 12);
                default: write_reg(CFG_LENGTH, 12 + 12 * n_max + $urandom_range(0, 40));
            endcase
            if ($urandom % 3 == 0)
                write_reg(CFG_MAGIC, $urandom);
            repeat ($urandom_range(1, 4)) begin
                n = $urandom_range(0, n_max);
                send_image(n, $urandom_range(0, 8), pick_flaw());
            end
            wait_drained();
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS container_index_parser");
        else
            $display("FAIL container_index_parser");
        $finish;
    end

endmodule
